// ----- hw/rtl/cscan_pkg.sv -----
`timescale 1ns / 1ps

package cscan_pkg;

    // Default text length limit; byte positions stop counting here
    localparam int MAX_TEXT_BYTES_DEF = 65536;

    // Field widths of a result word
    localparam int KIND_W  = 2;
    localparam int START_W = 16;
    localparam int END_W   = 17;

    // Result queue size
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // Match kinds
    localparam logic [KIND_W-1:0] KIND_CARD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SSN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_CARD_EN = 1'b0;
    localparam logic CFG_SSN_EN  = 1'b1;

    // One result word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start_off;
        logic [END_W-1:0]   end_off;
        logic               last;
    } result_t;

    // Up to two result words pushed in one cycle, r0 first
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } res_push_t;

endpackage

// ----- hw/rtl/cscan_core.sv -----
`timescale 1ns / 1ps

module cscan_core #(
    parameter int MAX_TEXT_BYTES = cscan_pkg::MAX_TEXT_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_byte,
    input  logic                s_final_byte,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic                cfg_wdata,
    input  logic                rq_room,
    output cscan_pkg::res_push_t push
);

    localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_TEXT_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT_BYTES - 1);
    localparam logic [4:0]       LEN_SAT  = 5'd17;
    localparam logic [7:0]       CH_DASH  = 8'h2D;

    // Card prefix and length rules
    function automatic logic is_card(input logic all_dig, input logic [4:0] len,
                                     input logic [3:0] d1, input logic [3:0] d2);
        logic hit;
        hit = 1'b0;
        if ((len == 5'd13 || len == 5'd16) && d1 == 4'd4)
            hit = 1'b1;
        if (len == 5'd16 && d1 == 4'd5 && d2 >= 4'd1 && d2 <= 4'd5)
            hit = 1'b1;
        if (len == 5'd15 && d1 == 4'd3 && (d2 == 4'd4 || d2 == 4'd7))
            hit = 1'b1;
        return hit & all_dig;
    endfunction

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_fin_reg;
    logic       advance;

    // Configuration
    logic card_en_reg, ssn_en_reg;

    // Scan state
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             inside_reg,   inside_next;
    logic [15:0]      wstart_reg,   wstart_next;
    logic [4:0]       wlen_reg,     wlen_next;
    logic             alldig_reg,   alldig_next;
    logic [3:0]       d1_reg,       d1_next;
    logic [3:0]       d2_reg,       d2_next;
    logic [1:0]       phase_reg,    phase_next;
    logic [15:0]      sstart_reg,   sstart_next;

    // Combinational working signals
    logic             is_digit, is_word;
    logic [3:0]       val;
    logic [POS_W-1:0] off, pos_inc;
    logic [POS_W+16:0] off_ext, cur_ext, len_ext;
    logic [15:0]      off16;
    logic [4:0]       w_len;
    logic             w_alldig;
    logic [3:0]       w_d1, w_d2;
    logic [15:0]      w_start;
    logic             judge, dash;
    logic [16:0]      judge_end;
    logic             card_hit, ssn_hit;
    logic [1:0]       ph_after;
    logic             set_sstart;
    cscan_pkg::result_t r_judge, r_mark;

    assign advance = in_valid_reg && rq_room;
    assign s_ready = !in_valid_reg || advance;

    // Input word capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_fin_reg  <= s_final_byte;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            card_en_reg <= 1'b1;
            ssn_en_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            if (cfg_addr == cscan_pkg::CFG_CARD_EN)
                card_en_reg <= cfg_wdata;
            if (cfg_addr == cscan_pkg::CFG_SSN_EN)
                ssn_en_reg <= cfg_wdata;
        end
    end

    // Byte classes and offsets
    always_comb begin
        is_digit = in_byte_reg >= 8'h30 && in_byte_reg <= 8'h39;
        is_word  = is_digit || (in_byte_reg >= 8'h41 && in_byte_reg <= 8'h5A) ||
                   (in_byte_reg >= 8'h61 && in_byte_reg <= 8'h7A) || in_byte_reg == 8'h5F;
        val      = is_digit ? in_byte_reg[3:0] : 4'd0;
        off      = (pos_reg < POS_MAX) ? pos_reg : POS_LAST;
        pos_inc  = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        off_ext  = {17'd0, off};
        cur_ext  = {17'd0, pos_reg};
        len_ext  = {17'd0, pos_inc};
        off16    = off_ext[15:0];
    end

    // Word tracking after this byte
    always_comb begin
        w_start  = wstart_reg;
        w_len    = wlen_reg;
        w_alldig = alldig_reg;
        w_d1     = d1_reg;
        w_d2     = d2_reg;
        if (is_word) begin
            if (!inside_reg) begin
                w_start  = off16;
                w_len    = 5'd1;
                w_alldig = is_digit;
                w_d1     = val;
                w_d2     = 4'd0;
            end else begin
                if (wlen_reg < LEN_SAT)
                    w_len = wlen_reg + 5'd1;
                w_alldig = alldig_reg & is_digit;
                if (w_len == 5'd2)
                    w_d2 = val;
            end
        end
    end

    // Word judgement: at a non-word byte ending a word, or at a final byte inside one
    always_comb begin
        judge      = is_word ? in_fin_reg : inside_reg;
        judge_end  = is_word ? len_ext[16:0] : cur_ext[16:0];
        dash       = !is_word && in_byte_reg == CH_DASH;
        card_hit   = judge && card_en_reg && is_card(w_alldig, w_len, w_d1, w_d2);
        ssn_hit    = judge && ssn_en_reg && phase_reg == 2'd2 && w_alldig && w_len == 5'd4;
        ph_after   = 2'd0;
        set_sstart = 1'b0;
        if (dash && w_alldig) begin
            if (w_len == 5'd3) begin
                ph_after   = 2'd1;
                set_sstart = 1'b1;
            end else if (w_len == 5'd2 && phase_reg == 2'd1) begin
                ph_after = 2'd2;
            end
        end
    end

    // Next scan state
    always_comb begin
        pos_next    = pos_inc;
        inside_next = inside_reg;
        wstart_next = w_start;
        wlen_next   = w_len;
        alldig_next = w_alldig;
        d1_next     = w_d1;
        d2_next     = w_d2;
        phase_next  = phase_reg;
        sstart_next = sstart_reg;
        if (in_fin_reg) begin
            pos_next    = '0;
            inside_next = 1'b0;
            wstart_next = '0;
            wlen_next   = '0;
            alldig_next = 1'b1;
            d1_next     = '0;
            d2_next     = '0;
            phase_next  = '0;
            sstart_next = '0;
        end else if (is_word) begin
            inside_next = 1'b1;
        end else if (inside_reg) begin
            inside_next = 1'b0;
            phase_next  = ph_after;
            if (set_sstart)
                sstart_next = w_start;
        end else begin
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            inside_reg <= 1'b0;
            wstart_reg <= '0;
            wlen_reg   <= '0;
            alldig_reg <= 1'b1;
            d1_reg     <= '0;
            d2_reg     <= '0;
            phase_reg  <= '0;
            sstart_reg <= '0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            inside_reg <= inside_next;
            wstart_reg <= wstart_next;
            wlen_reg   <= wlen_next;
            alldig_reg <= alldig_next;
            d1_reg     <= d1_next;
            d2_reg     <= d2_next;
            phase_reg  <= phase_next;
            sstart_reg <= sstart_next;
        end
    end

    // Result words; card and SSN hits never coincide (length differs)
    always_comb begin
        r_judge.kind      = card_hit ? cscan_pkg::KIND_CARD : cscan_pkg::KIND_SSN;
        r_judge.start_off = card_hit ? w_start : sstart_reg;
        r_judge.end_off   = judge_end;
        r_judge.last      = 1'b0;
        r_mark.kind       = cscan_pkg::KIND_END;
        r_mark.start_off  = '0;
        r_mark.end_off    = len_ext[16:0];
        r_mark.last       = 1'b1;

        push.r0 = r_judge;
        push.r1 = r_mark;
        if (!advance) begin
            push.count = 2'd0;
        end else if (card_hit || ssn_hit) begin
            push.count = in_fin_reg ? 2'd2 : 2'd1;
        end else begin
            push.count = in_fin_reg ? 2'd1 : 2'd0;
            push.r0    = r_mark;
        end
    end

endmodule

// ----- hw/rtl/cscan_rq.sv -----
`timescale 1ns / 1ps

module cscan_rq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cscan_pkg::res_push_t push,
    output logic                 rq_room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cscan_pkg::result_t   head
);

    localparam int AW = cscan_pkg::RQ_AW;
    localparam int CW = cscan_pkg::RQ_CW;

    cscan_pkg::result_t mem_reg [cscan_pkg::RQ_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          pop;
    logic [AW-1:0] wr_ptr_b;

    assign pop      = m_valid && m_ready;
    assign m_valid  = count_reg != '0;
    assign head     = mem_reg[rd_ptr_reg];
    // room for two words, judged without the pop of this cycle
    assign rq_room  = count_reg <= CW'(cscan_pkg::RQ_DEPTH - 2);
    assign wr_ptr_b = wr_ptr_reg + 1'b1;

    // Storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_b] <= push.r1;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CW'(push.count) - CW'(pop);
        end
    end

endmodule

// ----- hw/rtl/card_and_ssn_number_scanner.sv -----
`timescale 1ns / 1ps

// Card number and SSN scanner.
// Input channel (s_*): one text byte per word, s_final_byte marks the last
// byte of a text. Result channel (m_*): card (kind 0) and SSN (kind 1)
// matches with start and exclusive end offsets, in the order they end, then
// one end-of-text word (kind 2, m_last_result high) per text.
// cfg_wr_en/cfg_addr/cfg_wdata write card_enable (0) and ssn_enable (1);
// write only while the scanner is idle.
// A byte waits in the input register until the queue has room for two words; its
// results then enter a four-deep result queue and are offered on m_* from then on.
// Throughput: one byte per cycle. The input register advances while the
// queue holds at most two words; with the receiver always ready, a final
// byte that yields two words stalls the input only when it
// meets a queue that still holds two earlier words.
// Receiver stall: once the queue holds more than two words, s_ready drops; nothing is lost.
// Reset: the queue empties, scan state clears, both enables read 1.
// Byte offsets stop counting at MAX_TEXT_BYTES.

module card_and_ssn_number_scanner #(
    parameter int MAX_TEXT_BYTES = cscan_pkg::MAX_TEXT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_match_kind,
    output logic [15:0] m_start_offset,
    output logic [16:0] m_end_offset,
    output logic        m_last_result,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic        cfg_wdata
);

    cscan_pkg::res_push_t push;
    cscan_pkg::result_t   head;
    logic                 rq_room;

    cscan_core #(
        .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_final_byte(s_final_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .rq_room     (rq_room),
        .push        (push)
    );

    cscan_rq u_rq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .rq_room(rq_room),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .head   (head)
    );

    assign m_match_kind   = head.kind;
    assign m_start_offset = head.start_off;
    assign m_end_offset   = head.end_off;
    assign m_last_result  = head.last;

endmodule

// ----- hw/rtl/cscan_chk.sv -----
`timescale 1ns / 1ps

module cscan_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_match_kind,
    input logic [15:0] m_start_offset,
    input logic [16:0] m_end_offset,
    input logic        m_last_result
);

    // A stalled result word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // Reset empties the result queue
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only the end marker closes a text
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_result |-> m_match_kind == cscan_pkg::KIND_END)
        else $error("last flag on a match word");

    // End marker has a zero start and the last flag
    a_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_match_kind == cscan_pkg::KIND_END |-> m_start_offset == 16'd0 && m_last_result)
        else $error("malformed end marker");

endmodule

bind card_and_ssn_number_scanner cscan_chk u_cscan_chk (.*);
